/* sv/twodp_pkg.sv */
`default_nettype none

package twodp_pkg;

  // field widths of the words on both channels
  localparam int VALUE_W   = 16;
  localparam int DIFF_W    = 17;
  localparam int PROD_W    = 33;
  localparam int ACC_W     = 40;
  localparam int IDX_W     = 6;
  localparam int MODE_W    = 2;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  // input word modes
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MEAN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EIGEN  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_OUTPUTS = 2'd2;

  // controls from the sequencer to the shared mac
  typedef struct packed {
    logic diff_en;
    logic mul_en;
    logic first;
  } mac_ctrl_t;

endpackage

`default_nettype wire

/* sv/twodp_if.sv */
`default_nettype none

interface twodp_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [twodp_pkg::MODE_W-1:0]          mode;
  logic signed [twodp_pkg::VALUE_W-1:0]  sample_value;
  logic [twodp_pkg::IDX_W-1:0]           load_row;
  logic [twodp_pkg::IDX_W-1:0]           load_col;

  modport source (output valid, mode, sample_value, load_row, load_col, input ready);
  modport sink   (input valid, mode, sample_value, load_row, load_col, output ready);
endinterface

interface twodp_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [twodp_pkg::ACC_W-1:0]    coefficient;
  logic [twodp_pkg::IDX_W-1:0]           out_row;
  logic [twodp_pkg::IDX_W-1:0]           out_index;
  logic                                  last_in_row;
  logic                                  last_of_matrix;

  modport source (output valid, coefficient, out_row, out_index, last_in_row,
                  last_of_matrix, input ready);
  modport sink   (input valid, coefficient, out_row, out_index, last_in_row,
                  last_of_matrix, output ready);
endinterface

`default_nettype wire

/* sv/two_d_pca_projection.sv */
`default_nettype none

// channel   dir  handshake      word
// in_if     in   valid/ready    mode, sample_value, load_row, load_col
// out_if    out  valid/ready    coefficient, out_row, out_index, last_in_row,
//                               last_of_matrix
// cfg       in   cfg_we_i       cfg_idx_i, cfg_data_i (write only, no wait)
//
// a load word is written straight from idle; a sample word runs the single
// shared multiply-accumulate loop (read, multiply, add per output column),
// which stalls on the last column while the output register holds a full slot
// after reset the mean store is zeroed one entry a cycle over all MAX_ROWS*MAX_COLS
// entries, and in_if.ready stays low until that pass is done
// one output register sits between the loop and out_if

module two_d_pca_projection #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLS    = 64,
  parameter int MAX_OUTPUTS = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  twodp_in_if.sink                              in_if,
  twodp_out_if.source                           out_if,
  input  wire logic                             cfg_we_i,
  input  wire logic [twodp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [twodp_pkg::CFG_W-1:0]      cfg_data_i
);
  import twodp_pkg::*;

  // position and count widths
  localparam int RW         = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW         = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int KW         = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int RCW        = $clog2(MAX_ROWS + 1);
  localparam int CCW        = $clog2(MAX_COLS + 1);
  localparam int KCW        = $clog2(MAX_OUTPUTS + 1);
  localparam int MEAN_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int EIG_DEPTH  = MAX_COLS * MAX_OUTPUTS;
  localparam int MEAN_AW    = (MEAN_DEPTH > 1) ? $clog2(MEAN_DEPTH) : 1;
  localparam int EIG_AW     = (EIG_DEPTH > 1) ? $clog2(EIG_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_READ,
    S_MUL,
    S_ACC
  } state_e;

  state_e state_q;

  // configuration registers, raw as written
  logic [CFG_W-1:0] num_rows_q, num_cols_q, num_outputs_q;
  logic [RCW-1:0]   nrows;
  logic [CCW-1:0]   ncols;
  logic [KCW-1:0]   nout;

  // matrix position and output column counter
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic [KW-1:0] k_q;

  // mean store clearing pass
  logic               clearing_q;
  logic [MEAN_AW-1:0] clr_cnt_q;

  // latched sample
  logic signed [VALUE_W-1:0] sample_q;

  // stores
  logic signed [VALUE_W-1:0] mean_mem_q [0:MEAN_DEPTH-1];
  logic signed [VALUE_W-1:0] eig_mem_q  [0:EIG_DEPTH-1];
  logic [ACC_W-1:0]          acc_mem_q  [0:MAX_OUTPUTS-1];
  logic signed [VALUE_W-1:0] mean_rd_q, eig_rd_q;
  logic [ACC_W-1:0]          acc_rd_q;

  // output register
  logic                     out_valid_q;
  logic signed [ACC_W-1:0]  out_coef_q;
  logic [IDX_W-1:0]         out_row_q, out_idx_q;
  logic                     out_lir_q, out_lom_q;

  logic in_fire, is_sample, is_mean_ld, is_eig_ld, mean_ld_ok, eig_ld_ok;
  logic last_col, last_row, last_k, out_free, acc_step;
  logic               mean_we;
  logic [MEAN_AW-1:0] mean_wa, mean_ra;
  logic [VALUE_W-1:0] mean_wd;
  logic [EIG_AW-1:0]  eig_wa, eig_ra;
  logic [ACC_W-1:0]   sum;
  mac_ctrl_t          mac_ctrl;

  // zero acts as one, anything past the maximum saturates
  always_comb begin
    if (num_rows_q == '0) nrows = RCW'(1);
    else if (32'(num_rows_q) > MAX_ROWS) nrows = RCW'(MAX_ROWS);
    else nrows = RCW'(num_rows_q);

    if (num_cols_q == '0) ncols = CCW'(1);
    else if (32'(num_cols_q) > MAX_COLS) ncols = CCW'(MAX_COLS);
    else ncols = CCW'(num_cols_q);

    if (num_outputs_q == '0) nout = KCW'(1);
    else if (32'(num_outputs_q) > MAX_OUTPUTS) nout = KCW'(MAX_OUTPUTS);
    else nout = KCW'(num_outputs_q);
  end

  assign in_if.ready = (state_q == S_IDLE) && !clearing_q;
  assign in_fire     = in_if.valid && in_if.ready;
  assign is_sample   = in_fire && (in_if.mode == MODE_SAMPLE);
  assign is_mean_ld  = in_fire && (in_if.mode == MODE_MEAN);
  assign is_eig_ld   = in_fire && (in_if.mode == MODE_EIGEN);

  // loads outside the store are dropped
  assign mean_ld_ok = (32'(in_if.load_row) < MAX_ROWS) && (32'(in_if.load_col) < MAX_COLS);
  assign eig_ld_ok  = (32'(in_if.load_row) < MAX_COLS) && (32'(in_if.load_col) < MAX_OUTPUTS);

  assign last_col = (CCW'(col_q) + CCW'(1)) == ncols;
  assign last_row = (RCW'(row_q) + RCW'(1)) == nrows;
  assign last_k   = (KCW'(k_q) + KCW'(1)) == nout;

  // an accumulate step goes ahead unless a row result waits on a full slot
  assign out_free = !out_valid_q || out_if.ready;
  assign acc_step = (state_q == S_ACC) && (!last_col || out_free);

  // store addressing
  assign mean_ra = MEAN_AW'(32'(row_q) * MAX_COLS + 32'(col_q));
  assign mean_we = clearing_q || (is_mean_ld && mean_ld_ok);
  assign mean_wa = clearing_q ? clr_cnt_q
                              : MEAN_AW'(32'(in_if.load_row) * MAX_COLS + 32'(in_if.load_col));
  assign mean_wd = clearing_q ? '0 : in_if.sample_value;
  assign eig_wa  = EIG_AW'(32'(in_if.load_row) * MAX_OUTPUTS + 32'(in_if.load_col));
  assign eig_ra  = EIG_AW'(32'(col_q) * MAX_OUTPUTS + 32'(k_q));

  always_ff @(posedge clk_i) begin
    if (mean_we) begin
      mean_mem_q[mean_wa] <= mean_wd;
    end
    if (is_sample) begin
      mean_rd_q <= mean_mem_q[mean_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_eig_ld && eig_ld_ok) begin
      eig_mem_q[eig_wa] <= in_if.sample_value;
    end
    if (state_q == S_READ) begin
      eig_rd_q <= eig_mem_q[eig_ra];
    end
  end

  // accumulators never need clearing: the first column overwrites
  always_ff @(posedge clk_i) begin
    if (acc_step && !last_col) begin
      acc_mem_q[k_q] <= sum;
    end
    if (state_q == S_READ) begin
      acc_rd_q <= acc_mem_q[k_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_sample) begin
      sample_q <= in_if.sample_value;
    end
  end

  always_comb begin
    mac_ctrl.diff_en = (state_q == S_DIFF);
    mac_ctrl.mul_en  = (state_q == S_MUL);
    mac_ctrl.first   = (col_q == '0);
  end

  twodp_mac u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .sample_i (sample_q),
    .mean_i   (mean_rd_q),
    .coef_i   (eig_rd_q),
    .acc_i    (acc_rd_q),
    .sum_o    (sum)
  );

  // sequencer, positions, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      num_rows_q    <= CFG_W'(64);
      num_cols_q    <= CFG_W'(64);
      num_outputs_q <= CFG_W'(64);
      row_q         <= '0;
      col_q         <= '0;
      k_q           <= '0;
      clearing_q    <= 1'b1;
      clr_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + MEAN_AW'(1);
        if (clr_cnt_q == MEAN_AW'(MEAN_DEPTH - 1)) begin
          clearing_q <= 1'b0;
        end
      end

      // any register write restarts the matrix
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_NUM_ROWS: begin
            num_rows_q <= cfg_data_i;
            row_q      <= '0;
            col_q      <= '0;
          end
          REG_NUM_COLS: begin
            num_cols_q <= cfg_data_i;
            row_q      <= '0;
            col_q      <= '0;
          end
          REG_NUM_OUTPUTS: begin
            num_outputs_q <= cfg_data_i;
            row_q         <= '0;
            col_q         <= '0;
          end
          default: begin
          end
        endcase
      end

      // a new row result fills the slot, otherwise a taken word empties it
      if (acc_step && last_col) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (is_sample) begin
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          k_q     <= '0;
          state_q <= S_READ;
        end
        S_READ: begin
          state_q <= S_MUL;
        end
        S_MUL: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (acc_step) begin
            if (last_col) begin
              out_coef_q  <= sum;
              out_row_q   <= IDX_W'(row_q);
              out_idx_q   <= IDX_W'(k_q);
              out_lir_q   <= last_k;
              out_lom_q   <= last_k && last_row;
            end
            if (last_k) begin
              state_q <= S_IDLE;
              if (last_col) begin
                col_q <= '0;
                row_q <= last_row ? '0 : row_q + RW'(1);
              end else begin
                col_q <= col_q + CW'(1);
              end
            end else begin
              k_q     <= k_q + KW'(1);
              state_q <= S_READ;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.coefficient    = out_coef_q;
  assign out_if.out_row        = out_row_q;
  assign out_if.out_index      = out_idx_q;
  assign out_if.last_in_row    = out_lir_q;
  assign out_if.last_of_matrix = out_lom_q;

endmodule

`default_nettype wire

/* sv/twodp_mac.sv */
`default_nettype none

module twodp_mac (
  input  wire logic                                  clk_i,
  input  wire twodp_pkg::mac_ctrl_t                  ctrl_i,
  input  wire logic signed [twodp_pkg::VALUE_W-1:0]  sample_i,
  input  wire logic signed [twodp_pkg::VALUE_W-1:0]  mean_i,
  input  wire logic signed [twodp_pkg::VALUE_W-1:0]  coef_i,
  input  wire logic [twodp_pkg::ACC_W-1:0]           acc_i,
  output logic [twodp_pkg::ACC_W-1:0]                sum_o
);
  import twodp_pkg::*;

  logic signed [DIFF_W-1:0] diff_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]         base;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.diff_en) begin
      diff_q <= DIFF_W'(sample_i) - DIFF_W'(mean_i);
    end
    if (ctrl_i.mul_en) begin
      prod_q <= PROD_W'(diff_q) * PROD_W'(coef_i);
    end
  end

  // first column of a row starts a fresh sum
  assign base  = ctrl_i.first ? '0 : acc_i;
  assign sum_o = base + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

endmodule

`default_nettype wire
